[rtl/spjq_pkg.sv]
// Package for the stable priority job queue.
// Holds the cell entry and command types and the status codes.
// No dependencies.
package spjq_pkg;

  localparam int KEY_W  = 16;
  localparam int JOB_W  = 16;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // Input mode codes.
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // One queue slot.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [JOB_W-1:0] job;
  } entry_t;

  // Command broadcast to every cell.
  typedef struct packed {
    logic             en;
    logic             remove;
    logic [KEY_W-1:0] key;
    logic [JOB_W-1:0] job;
  } cmd_t;

endpackage

[rtl/spjq_cell.sv]
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on spjq_pkg.
module spjq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spjq_pkg::cmd_t cmd_i,
  input  spjq_pkg::entry_t left_i,
  input  logic           left_gt_i,
  input  spjq_pkg::entry_t right_i,
  output spjq_pkg::entry_t ent_o,
  output logic           gt_o
);

  spjq_pkg::entry_t ent_r;
  spjq_pkg::entry_t ent_nxt;

  // An empty slot counts as greater, so a job with no greater key lands at the first free slot.
  assign gt_o  = !ent_r.valid || (ent_r.key > cmd_i.key);
  assign ent_o = ent_r;

  // Removal shifts toward the front; insert shifts greater entries back by one.
  always_comb begin
    ent_nxt = ent_r;
    if (cmd_i.en) begin
      if (cmd_i.remove) begin
        ent_nxt = right_i;
      end else if (gt_o) begin
        if (!left_gt_i) begin
          ent_nxt.valid = 1'b1;
          ent_nxt.key   = cmd_i.key;
          ent_nxt.job   = cmd_i.job;
        end else begin
          ent_nxt = left_i;
        end
      end
    end
  end

  // Only the valid bit is reset; key and job follow it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
    ent_r.key <= ent_nxt.key;
    ent_r.job <= ent_nxt.job;
  end

endmodule

[rtl/stable_priority_job_queue.sv]
// Stable priority job queue: one insert or removal is accepted every cycle that
// in_ready is high and gives one result beat, registered, on the cycle after
// acceptance. Jobs sit in a row of CAPACITY cells kept in ascending key order,
// equal keys in arrival order; every cell compares its key with the broadcast
// key of an insert, and that 16-bit compare plus the neighbor select sets the
// cycle path. An insert into a full queue and a removal from an empty one leave
// the queue unchanged and are flagged in status. Occupancy is the count after
// the item, low 5 bits. Depends on spjq_pkg and spjq_cell.
module stable_priority_job_queue #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [15:0] in_job_id,
  input  logic [15:0] in_time_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_removed_job,
  output logic [15:0] out_removed_key,
  output logic [1:0]  out_status,
  output logic [4:0]  out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  spjq_pkg::cmd_t   cmd;
  spjq_pkg::entry_t ents [CAPACITY];
  logic             gts  [CAPACITY];
  spjq_pkg::entry_t empty_ent;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  logic [15:0]      rjob_r, rjob_nxt;
  logic [15:0]      rkey_r, rkey_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [CNT_W+4:0] occ_r;

  logic accept, is_full, is_empty;

  // A new beat is taken whenever the output register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  assign empty_ent = '0;

  // Broadcast command; blocked items do not touch the cells.
  always_comb begin
    cmd.remove = (in_mode == spjq_pkg::MODE_REMOVE);
    cmd.key    = in_time_key;
    cmd.job    = in_job_id;
    cmd.en     = accept && (cmd.remove ? !is_empty : !is_full);
  end

  // The row of cells, each linked to its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spjq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd_i     (cmd),
      .left_i    ((i == 0) ? empty_ent : ents[(i == 0) ? 0 : i - 1]),
      .left_gt_i ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i - 1]),
      .right_i   ((i == CAPACITY - 1) ? empty_ent
                                      : ents[(i == CAPACITY - 1) ? i : i + 1]),
      .ent_o     (ents[i]),
      .gt_o      (gts[i])
    );
  end

  // Next count and result fields.
  always_comb begin
    count_nxt = count_r;
    rjob_nxt  = '0;
    rkey_nxt  = '0;
    stat_nxt  = spjq_pkg::STAT_OK;
    if (cmd.remove) begin
      if (is_empty) begin
        stat_nxt = spjq_pkg::STAT_UNDERFLOW;
      end else begin
        rjob_nxt  = ents[0].job;
        rkey_nxt  = ents[0].key;
        count_nxt = count_r - 1'b1;
      end
    end else begin
      if (is_full) begin
        stat_nxt = spjq_pkg::STAT_FULL;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (accept) begin
      rjob_r <= rjob_nxt;
      rkey_r <= rkey_nxt;
      stat_r <= stat_nxt;
      occ_r  <= {5'b0, count_nxt};
    end
  end

  assign out_valid       = out_valid_r;
  assign out_removed_job = rjob_r;
  assign out_removed_key = rkey_r;
  assign out_status      = stat_r;
  assign out_occupancy   = occ_r[4:0];

endmodule

[rtl/spjq_checker.sv]
// Port-level checks for the stable priority job queue, bound to the top level.
// Depends on spjq_pkg and stable_priority_job_queue.
module spjq_checker #(
  parameter int CAPACITY = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_removed_job,
  input logic [15:0] out_removed_key,
  input logic [1:0]  out_status,
  input logic [4:0]  out_occupancy
);

  logic       out_fire;
  logic [4:0] occ_prev_r;
  logic [4:0] occ_step;

  // Occupancy seen at the previous edge, for the step check.
  always_ff @(posedge clk) begin
    occ_prev_r <= out_occupancy;
  end

  assign out_fire = out_valid && out_ready;
  assign occ_step = out_occupancy - occ_prev_r;

  // A stalled result beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_removed_job)
      && $stable(out_removed_key) && $stable(out_status) && $stable(out_occupancy))
    else $error("result beat changed while stalled");

  // An underflow reports an empty queue and no job.
  a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spjq_pkg::STAT_UNDERFLOW |->
      out_occupancy == 5'd0 && out_removed_job == 16'd0 && out_removed_key == 16'd0)
    else $error("underflow result is inconsistent");

  // A dropped insert reports a full queue and no job.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spjq_pkg::STAT_FULL |->
      out_occupancy == 5'(CAPACITY) && out_removed_job == 16'd0
      && out_removed_key == 16'd0)
    else $error("dropped insert result is inconsistent");

  // Back-to-back results move the occupancy by at most one.
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && $past(out_fire) && $past(rst_n) |->
      occ_step == 5'd0 || occ_step == 5'd1 || occ_step == 5'd31)
    else $error("occupancy jumped between results");

  // The input side is never blocked while the output register is empty.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no pending result");

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind stable_priority_job_queue spjq_checker #(.CAPACITY(CAPACITY)) u_spjq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_removed_job (out_removed_job),
  .out_removed_key (out_removed_key),
  .out_status      (out_status),
  .out_occupancy   (out_occupancy)
);
